>>> hdl/isotp_fr_pkg.sv
// ----------------------------------------------------------------------------
// ISO-TP frame reassembler package
// Request and result types, status and request codes, buffer constants.
// ----------------------------------------------------------------------------
package isotp_fr_pkg;

    localparam int unsigned FILL_W = 13;

    localparam logic [FILL_W-1:0] BUFFER_BYTES = 13'd4096;
    localparam logic [3:0]        MAX_SF_DL    = 4'd7;
    localparam logic [11:0]       MIN_FF_DL    = 12'd6;
    localparam logic [2:0]        FF_BYTES     = 3'd6;
    localparam logic [2:0]        CF_BYTES     = 3'd7;
    localparam logic [3:0]        FIRST_SEQ    = 4'd1;

    typedef enum logic [1:0] {
        REQ_SINGLE = 2'd0,
        REQ_FIRST  = 2'd1,
        REQ_CONSEC = 2'd2,
        REQ_DRAIN  = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_DONE = 3'd1,
        ST_SEQ  = 3'd2,
        ST_OVF  = 3'd3,
        ST_ERR  = 3'd4
    } status_t;

    typedef struct packed {
        req_kind_t   req_type;
        logic [63:0] frame_payload;
        logic [11:0] drained_length;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  accepted_bytes;
        logic [55:0] data_bytes;
        logic        message_done;
        logic [11:0] message_length;
    } rsp_t;

endpackage

>>> hdl/isotp_frame_reassembler_unit.sv
// ----------------------------------------------------------------------------
// ISO-TP frame reassembler
// Receive-side reassembly of classified CAN frames into ISO-TP messages.
//
// Requests arrive on the s_ channel (valid/ready) as a classified frame
// (single, first, consecutive) or a buffer drain notice. Each request gives
// exactly one result on the m_ channel (valid/ready): status, the payload
// bytes taken into the message and, on completion, the message length.
// cfg_wr_en/cfg_wr_data write the addressing mode bit; write it only while
// no request is in flight.
// A request passes an input register, then the update logic, then a result
// register: m_valid rises once the request has moved from the input register
// into the result register. One request per cycle is sustained while the
// receiver accepts results; the reassembly state is updated in the same cycle
// a request moves into the result register.
// When the receiver stalls, the result register holds and the input
// register takes one more request before s_ready drops.
// Reset clears the valid flags and reassembly state and sets standard addressing.
// ----------------------------------------------------------------------------
module isotp_frame_reassembler_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  isotp_fr_pkg::req_t  s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output isotp_fr_pkg::rsp_t  m_rsp
);

    logic               in_valid_reg, in_valid_next;
    isotp_fr_pkg::req_t in_req_reg;
    logic               out_valid_reg, out_valid_next;
    isotp_fr_pkg::rsp_t out_rsp_reg;
    isotp_fr_pkg::rsp_t core_rsp;
    logic               advance;
    logic               take;

    isotp_fr_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (advance),
        .req         (in_req_reg),
        .rsp         (core_rsp)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_req_reg <= s_req;
        end
        if (advance) begin
            out_rsp_reg <= core_rsp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_rsp   = out_rsp_reg;

endmodule

>>> hdl/isotp_fr_core.sv
// ----------------------------------------------------------------------------
// ISO-TP frame reassembler core
// Reassembly state, addressing register and the per-request update logic.
// ----------------------------------------------------------------------------
module isotp_fr_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                req_valid,
    input  isotp_fr_pkg::req_t  req,
    output isotp_fr_pkg::rsp_t  rsp
);

    logic                              std_addr_reg;
    logic [3:0]                        exp_seq_reg, exp_seq_next;
    logic [11:0]                       msg_total_reg, msg_total_next;
    logic [11:0]                       msg_rcvd_reg, msg_rcvd_next;
    logic                              in_msg_reg, in_msg_next;
    logic [isotp_fr_pkg::FILL_W-1:0]   fill_reg, fill_next;

    logic [3:0]                        nib;
    logic [11:0]                       ff_len;
    logic [11:0]                       remaining;
    logic [2:0]                        step;
    logic [isotp_fr_pkg::FILL_W:0]     sf_sum;
    logic [isotp_fr_pkg::FILL_W:0]     cf_sum;
    logic [isotp_fr_pkg::FILL_W-1:0]   room;

    function automatic logic [55:0] keep_bytes(input logic [55:0] d, input logic [2:0] cnt);
        logic [55:0] r;
        r = '0;
        for (int i = 0; i < 7; i++) begin
            if (3'(i) < cnt) begin
                r[8*i +: 8] = d[8*i +: 8];
            end
        end
        return r;
    endfunction

    assign nib       = req.frame_payload[3:0];
    assign ff_len    = {nib, req.frame_payload[15:8]};
    assign remaining = (msg_total_reg > msg_rcvd_reg) ? msg_total_reg - msg_rcvd_reg : 12'd0;
    assign step      = (remaining < 12'(isotp_fr_pkg::CF_BYTES)) ? remaining[2:0]
                                                                 : isotp_fr_pkg::CF_BYTES;
    assign sf_sum    = {1'b0, fill_reg} + {{(isotp_fr_pkg::FILL_W-3){1'b0}}, nib};
    assign cf_sum    = {1'b0, fill_reg} + {{(isotp_fr_pkg::FILL_W-2){1'b0}}, step};
    assign room      = isotp_fr_pkg::BUFFER_BYTES - fill_reg;

    always_comb begin
        exp_seq_next   = exp_seq_reg;
        msg_total_next = msg_total_reg;
        msg_rcvd_next  = msg_rcvd_reg;
        in_msg_next    = in_msg_reg;
        fill_next      = fill_reg;
        rsp            = '0;
        rsp.status     = isotp_fr_pkg::ST_OK;
        case (req.req_type)
            isotp_fr_pkg::REQ_SINGLE: begin
                if (!std_addr_reg || nib > isotp_fr_pkg::MAX_SF_DL) begin
                    rsp.status = isotp_fr_pkg::ST_ERR;
                end else if (nib != 4'd0) begin
                    if (sf_sum <= {1'b0, isotp_fr_pkg::BUFFER_BYTES}) begin
                        rsp.accepted_bytes = nib[2:0];
                        rsp.data_bytes     = keep_bytes(req.frame_payload[63:8], nib[2:0]);
                        rsp.message_done   = 1'b1;
                        rsp.message_length = {8'd0, nib};
                        fill_next          = sf_sum[isotp_fr_pkg::FILL_W-1:0];
                    end else begin
                        rsp.status = isotp_fr_pkg::ST_OVF;
                    end
                end
            end
            isotp_fr_pkg::REQ_FIRST: begin
                if (ff_len <= isotp_fr_pkg::MIN_FF_DL) begin
                    rsp.status  = isotp_fr_pkg::ST_ERR;
                    in_msg_next = 1'b0;
                end else if (fill_reg > isotp_fr_pkg::BUFFER_BYTES
                             || {1'b0, ff_len} > room) begin
                    rsp.status  = isotp_fr_pkg::ST_OVF;
                    in_msg_next = 1'b0;
                end else begin
                    msg_total_next     = ff_len;
                    msg_rcvd_next      = 12'(isotp_fr_pkg::FF_BYTES);
                    exp_seq_next       = isotp_fr_pkg::FIRST_SEQ;
                    in_msg_next        = 1'b1;
                    fill_next          = fill_reg + isotp_fr_pkg::FILL_W'(isotp_fr_pkg::FF_BYTES);
                    rsp.accepted_bytes = isotp_fr_pkg::FF_BYTES;
                    rsp.data_bytes     = {8'd0, req.frame_payload[63:16]};
                end
            end
            isotp_fr_pkg::REQ_CONSEC: begin
                if (!in_msg_reg) begin
                    rsp.status = isotp_fr_pkg::ST_ERR;
                end else if (nib != exp_seq_reg) begin
                    rsp.status = isotp_fr_pkg::ST_SEQ;
                end else if (cf_sum > {1'b0, isotp_fr_pkg::BUFFER_BYTES}) begin
                    rsp.status  = isotp_fr_pkg::ST_OVF;
                    in_msg_next = 1'b0;
                end else begin
                    rsp.accepted_bytes = step;
                    rsp.data_bytes     = keep_bytes(req.frame_payload[63:8], step);
                    fill_next          = cf_sum[isotp_fr_pkg::FILL_W-1:0];
                    msg_rcvd_next      = msg_rcvd_reg + {9'd0, step};
                    exp_seq_next       = exp_seq_reg + 4'd1;
                    if (remaining <= 12'(isotp_fr_pkg::CF_BYTES)) begin
                        rsp.status         = isotp_fr_pkg::ST_DONE;
                        rsp.message_done   = 1'b1;
                        rsp.message_length = msg_total_reg;
                        in_msg_next        = 1'b0;
                        exp_seq_next       = 4'd0;
                    end
                end
            end
            isotp_fr_pkg::REQ_DRAIN: begin
                if ({1'b0, req.drained_length} >= fill_reg) begin
                    fill_next = '0;
                end else begin
                    fill_next = fill_reg - {1'b0, req.drained_length};
                end
            end
            default: begin
                rsp.status = isotp_fr_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            std_addr_reg  <= 1'b1;
            exp_seq_reg   <= '0;
            msg_total_reg <= '0;
            msg_rcvd_reg  <= '0;
            in_msg_reg    <= 1'b0;
            fill_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                std_addr_reg <= cfg_wr_data;
            end
            if (req_valid) begin
                exp_seq_reg   <= exp_seq_next;
                msg_total_reg <= msg_total_next;
                msg_rcvd_reg  <= msg_rcvd_next;
                in_msg_reg    <= in_msg_next;
                fill_reg      <= fill_next;
            end
        end
    end

endmodule
